/* rtl/rmdp_pkg.sv */
// Package for the rate-monotonic deferred-preemption scheduler.
// Holds the job record, cell command and FSM types and the ordering helpers.
// No dependencies.
package rmdp_pkg;

    localparam int TASK_W = 6;
    localparam int JOB_W  = 16;
    localparam int KEY_W  = 17;
    localparam int DL_W   = 34;
    localparam int REM_W  = 16;
    localparam int WORK_W = 27;
    localparam int CMP_W  = 35;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ADDR_TASK_COUNT = 2'd0;

    typedef struct packed {
        logic              vld;
        logic [TASK_W-1:0] task_id;
        logic [JOB_W-1:0]  job;
        logic [KEY_W-1:0]  key;
        logic [DL_W-1:0]   deadline;
        logic [REM_W-1:0]  remain;
    } job_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_SHL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        job_t      ins_job;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL,
        ST_RET,
        ST_SCAN,
        ST_DECIDE,
        ST_REINS,
        ST_DONE
    } state_t;

    function automatic logic ranks_before(input job_t a, input job_t b);
        logic r;
        if (a.key != b.key) begin
            r = a.key < b.key;
        end else if (a.task_id != b.task_id) begin
            r = a.task_id < b.task_id;
        end else begin
            r = a.job < b.job;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] period_key(input logic [15:0] p);
        logic [KEY_W-1:0] k;
        if (p == 16'd0) begin
            k = 17'h10000;
        end else begin
            k = {1'b0, p};
        end
        return k;
    endfunction

endpackage

/* rtl/rmdp_cell.sv */
// One slot of the sorted ready-queue chain.
// Inserts in order from the left neighbor, shifts from the right neighbor.
// Depends on rmdp_pkg.
module rmdp_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  rmdp_pkg::cell_ctrl_t ctrl,
    input  rmdp_pkg::job_t      left_job,
    input  logic                left_b,
    input  rmdp_pkg::job_t      right_job,
    output rmdp_pkg::job_t      cell_job,
    output logic                cell_b
);
    import rmdp_pkg::*;

    job_t job_reg, job_next;

    assign cell_b   = !job_reg.vld || ranks_before(ctrl.ins_job, job_reg);
    assign cell_job = job_reg;

    always_comb begin
        job_next = job_reg;
        case (ctrl.cmd)
            CELL_INS: begin
                if (cell_b) begin
                    job_next = left_b ? left_job : ctrl.ins_job;
                end
            end
            CELL_SHL: job_next = right_job;
            default:  job_next = job_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg <= '0;
        end else begin
            job_reg <= job_next;
        end
    end

endmodule

/* rtl/rate_monotonic_deferred_preempt_sched.sv */
// Rate-monotonic periodic scheduler with deferred preemption, top level.
// Task table, FSM and tick datapath around a chain of ready-queue cells.
// Depends on rmdp_pkg and rmdp_cell.
//
// Usage:
//   s_ channel (valid/ready): s_operation 0 loads one task entry (no result),
//   1 advances one tick and yields one m_ transaction.
//   APB port: register 0 at address 0 is task_count; pready is always high.
// Sequence:
//   A load is written in the idle state. A tick runs a release scan over the
//   MAX_TASK_SLOTS slots (one slot per cycle, each release inserted into the
//   cell chain unless the queue is full), a retire step, a ring rotation through
//   the READY_DEPTH cells when a job is running (work summed and minimum deadline
//   taken at cell 0), a decide step, a re-insert step on preemption and an
//   output step.
// Reset: queue empty, no running job, counters zero, task_count 1.
// Stall: the result sits in the output register; the next item is taken
//   and worked on, and a tick waits in its output cycle until the register
//   frees.
module rate_monotonic_deferred_preempt_sched #(
    parameter int MAX_TASK_SLOTS = 16,
    parameter int READY_DEPTH    = 32,
    parameter int TIME_BITS      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [3:0]  s_task_index,
    input  logic [15:0] s_arrival_offset,
    input  logic [15:0] s_exec_budget,
    input  logic [15:0] s_task_period,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_time_now,
    output logic        m_running_valid,
    output logic [3:0]  m_running_task,
    output logic [15:0] m_active_job,
    output logic        m_switched,
    output logic        m_finished_valid,
    output logic [3:0]  m_finished_task,
    output logic [15:0] m_finished_job,
    output logic [15:0] m_idle_total,
    output logic [15:0] m_switch_total,
    output logic        m_queue_overflow
);
    import rmdp_pkg::*;

    localparam int SLOT_W = (MAX_TASK_SLOTS > 1) ? $clog2(MAX_TASK_SLOTS) : 1;
    localparam int RD_W   = $clog2(READY_DEPTH);
    localparam int FILL_W = $clog2(READY_DEPTH + 1);

    state_t state_reg, state_next;
    cell_ctrl_t ctrl;
    job_t ring_in;
    job_t cells [READY_DEPTH];
    logic cell_bs [READY_DEPTH];

    logic [SLOT_W-1:0] scan_reg;
    logic [RD_W-1:0]   rot_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [4:0]        task_count_reg;

    logic [15:0] arr_reg   [MAX_TASK_SLOTS];
    logic [15:0] bud_reg   [MAX_TASK_SLOTS];
    logic [15:0] per_reg   [MAX_TASK_SLOTS];
    logic [15:0] phase_reg [MAX_TASK_SLOTS];
    logic [15:0] relc_reg  [MAX_TASK_SLOTS];

    job_t cur_reg, back_reg;
    logic              last_valid_reg;
    logic [TASK_W-1:0] last_task_reg;
    logic [JOB_W-1:0]  last_job_reg;
    logic [TIME_BITS-1:0] tick_reg;
    logic [15:0] idle_reg, switch_reg;
    logic        ovf_reg, sw_reg, fin_reg;
    logic [TASK_W-1:0] fin_task_reg;
    logic [JOB_W-1:0]  fin_job_reg;
    logic [WORK_W-1:0] work_reg;
    logic [DL_W-1:0]   dmin_reg;

    logic s_fire, cfg_wr, out_free;
    logic [6:0] idx7, scan7;
    logic rel_hit, q_full, preempt, do_pop, scan_last, rot_last, cur_live;
    logic [KEY_W-1:0] rel_key;
    logic [16:0] phase_nx;
    logic [TIME_BITS+15:0] time_wide;
    job_t rel_job, head;

    assign pready   = 1'b1;
    assign prdata   = {27'd0, task_count_reg};
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_TASK_COUNT);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;
    assign idx7     = {3'd0, s_task_index};
    assign scan7    = 7'(scan_reg);
    assign scan_last = scan_reg == SLOT_W'(MAX_TASK_SLOTS - 1);
    assign rot_last  = rot_reg == RD_W'(READY_DEPTH - 1);
    assign q_full    = fill_reg >= FILL_W'(READY_DEPTH);
    assign head      = cells[0];
    assign cur_live  = cur_reg.vld && (cur_reg.remain != '0);

    assign rel_hit = (scan7 < {2'd0, task_count_reg}) &&
                     (phase_reg[scan_reg] == arr_reg[scan_reg]) &&
                     (bud_reg[scan_reg] != 16'd0);
    assign rel_key = period_key(per_reg[scan_reg]);
    assign phase_nx = {1'b0, phase_reg[scan_reg]} + 17'd1;

    always_comb begin
        rel_job          = '0;
        rel_job.vld      = 1'b1;
        rel_job.task_id  = TASK_W'(scan_reg);
        rel_job.job      = relc_reg[scan_reg];
        rel_job.key      = rel_key;
        rel_job.deadline = DL_W'(tick_reg) + DL_W'(rel_key);
        rel_job.remain   = bud_reg[scan_reg];
    end

    assign preempt = (work_reg != '0) &&
                     ((CMP_W'(tick_reg) + CMP_W'(work_reg)) > CMP_W'(dmin_reg));
    assign do_pop  = cur_reg.vld ? preempt : (fill_reg != '0);
    assign time_wide = {16'd0, tick_reg};

    genvar g;
    generate
        for (g = 0; g < READY_DEPTH; g++) begin : g_cell
            rmdp_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .left_job  ((g == 0) ? '0 : cells[(g == 0) ? 0 : g - 1]),
                .left_b    ((g == 0) ? 1'b0 : cell_bs[(g == 0) ? 0 : g - 1]),
                .right_job ((g == READY_DEPTH - 1) ? ring_in
                                                   : cells[(g == READY_DEPTH - 1) ? g : g + 1]),
                .cell_job  (cells[g]),
                .cell_b    (cell_bs[g])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_fire && s_operation == OP_TICK) state_next = ST_REL;
            ST_REL:    if (scan_last) state_next = ST_RET;
            ST_RET:    state_next = cur_live ? ST_SCAN : ST_DECIDE;
            ST_SCAN:   if (rot_last) state_next = ST_DECIDE;
            ST_DECIDE: state_next = (cur_reg.vld && preempt) ? ST_REINS : ST_DONE;
            ST_REINS:  state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl         = '0;
        ctrl.cmd     = CELL_HOLD;
        ctrl.ins_job = rel_job;
        ring_in      = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_REL:  if (rel_hit && !q_full) ctrl.cmd = CELL_INS;
            ST_SCAN: begin
                ctrl.cmd = CELL_SHL;
                ring_in  = cells[0];
            end
            ST_DECIDE: if (do_pop) ctrl.cmd = CELL_SHL;
            ST_REINS: begin
                ctrl.cmd     = CELL_INS;
                ctrl.ins_job = back_reg;
            end
            default: ctrl.cmd = CELL_HOLD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            task_count_reg <= 5'd1;
            scan_reg       <= '0;
            rot_reg        <= '0;
            fill_reg       <= '0;
            cur_reg        <= '0;
            back_reg       <= '0;
            last_valid_reg <= 1'b0;
            last_task_reg  <= '0;
            last_job_reg   <= '0;
            tick_reg       <= '0;
            idle_reg       <= '0;
            switch_reg     <= '0;
            ovf_reg        <= 1'b0;
            sw_reg         <= 1'b0;
            fin_reg        <= 1'b0;
            fin_task_reg   <= '0;
            fin_job_reg    <= '0;
            work_reg       <= '0;
            dmin_reg       <= '0;
            m_valid        <= 1'b0;
            for (int i = 0; i < MAX_TASK_SLOTS; i++) begin
                phase_reg[i] <= '0;
                relc_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr) task_count_reg <= pwdata[4:0];
            if (state_reg == ST_DONE && out_free) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    scan_reg <= '0;
                    ovf_reg  <= 1'b0;
                    sw_reg   <= 1'b0;
                    fin_reg  <= 1'b0;
                    fin_task_reg <= '0;
                    fin_job_reg  <= '0;
                    if (s_fire && s_operation == OP_LOAD &&
                        idx7 < 7'(MAX_TASK_SLOTS)) begin
                        arr_reg[idx7[SLOT_W-1:0]]   <= s_arrival_offset;
                        bud_reg[idx7[SLOT_W-1:0]]   <= s_exec_budget;
                        per_reg[idx7[SLOT_W-1:0]]   <= s_task_period;
                        phase_reg[idx7[SLOT_W-1:0]] <= '0;
                        relc_reg[idx7[SLOT_W-1:0]]  <= '0;
                    end
                end
                ST_REL: begin
                    if (rel_hit) begin
                        if (q_full) ovf_reg <= 1'b1;
                        else fill_reg <= fill_reg + 1'b1;
                    end
                    if (phase_nx >= rel_key) begin
                        phase_reg[scan_reg] <= '0;
                        if (relc_reg[scan_reg] != 16'hFFFF)
                            relc_reg[scan_reg] <= relc_reg[scan_reg] + 16'd1;
                    end else begin
                        phase_reg[scan_reg] <= phase_nx[15:0];
                    end
                    if (!scan_last) scan_reg <= scan_reg + 1'b1;
                end
                ST_RET: begin
                    rot_reg  <= '0;
                    work_reg <= '0;
                    dmin_reg <= '1;
                    if (cur_reg.vld && cur_reg.remain == '0) begin
                        fin_reg      <= 1'b1;
                        fin_task_reg <= cur_reg.task_id;
                        fin_job_reg  <= cur_reg.job;
                        cur_reg.vld  <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (head.vld && head.key < cur_reg.key) begin
                        work_reg <= work_reg + WORK_W'(head.remain);
                        if (head.deadline < dmin_reg) dmin_reg <= head.deadline;
                    end
                    rot_reg <= rot_reg + 1'b1;
                end
                ST_DECIDE: begin
                    if (do_pop) begin
                        cur_reg  <= head;
                        back_reg <= cur_reg;
                        if (!cur_reg.vld || !preempt) fill_reg <= fill_reg - 1'b1;
                        if (!last_valid_reg || last_task_reg != head.task_id ||
                            last_job_reg != head.job) begin
                            sw_reg         <= 1'b1;
                            if (switch_reg != 16'hFFFF) switch_reg <= switch_reg + 16'd1;
                            last_valid_reg <= 1'b1;
                            last_task_reg  <= head.task_id;
                            last_job_reg   <= head.job;
                        end
                    end else if (!cur_reg.vld) begin
                        last_valid_reg <= 1'b0;
                        if (idle_reg != 16'hFFFF) idle_reg <= idle_reg + 16'd1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        if (cur_reg.vld && cur_reg.remain != '0)
                            cur_reg.remain <= cur_reg.remain - 1'b1;
                        if (tick_reg != '1) tick_reg <= tick_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_time_now       <= time_wide[15:0];
            m_running_valid  <= cur_reg.vld;
            m_running_task   <= cur_reg.vld ? cur_reg.task_id[3:0] : 4'd0;
            m_active_job     <= cur_reg.vld ? cur_reg.job : 16'd0;
            m_switched       <= sw_reg;
            m_finished_valid <= fin_reg;
            m_finished_task  <= fin_task_reg[3:0];
            m_finished_job   <= fin_job_reg;
            m_idle_total     <= idle_reg;
            m_switch_total   <= switch_reg;
            m_queue_overflow <= ovf_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(READY_DEPTH))
        else $error("ready fill beyond depth");

    a_head_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cells[0].vld == (fill_reg != '0)))
        else $error("queue head valid disagrees with fill");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_running_valid) |-> (m_running_task == 4'd0 && m_active_job == 16'd0))
        else $error("idle tick reports a running job");
`endif

endmodule
